// ===== hw/rtl/mqsb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-queue shared buffer: request codes, status codes,
// controller state type and default sizes. Depends on nothing.
package mqsb_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int QUEUES_DEF = 4;
    localparam int QID_W      = 2;
    localparam int DATA_W     = 32;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_OVER  = 2'd1,
        STAT_UNDER = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== hw/rtl/multi_queue_shared_buffer_core.sv =====
`timescale 1ns / 1ps
// Top level of the multi-queue shared buffer: request handling, queue pointers and
// free list control. Uses mqsb_pkg and instantiates mqsb_store.
//
// Usage. Several FIFO queues share one store of SLOTS words. Each request on the
// s_axis channel either enqueues a word to a queue or dequeues the head of a queue;
// tuser carries the request kind, tdata the queue number and the word. Every request
// gives exactly one result on the m_axis channel: the dequeued word in tdata (zero
// for an enqueue or on error) and a status code in tuser (ok, overflow when no slot
// is free or an enqueue's queue is absent; underflow when empty or absent on dequeue).
//
// Request sequence. A request is accepted in the idle state, the memories are
// read at that edge, and in the following cycle the pointers and links are written
// back and the result is registered, to be offered from the output register. No new
// request is taken in that write-back cycle, which the read-modify-write of the link
// memory requires, as that memory has one read and one write port.
//
// Reset. The queues are empty and all slots are free. No clearing pass is run: a
// high-water count marks the slots whose link was ever written, and slots at or above
// it read as chained to the next slot, so requests are taken from the first cycle.
//
// Stalls. The result waits in the output register while m_axis_tready is low; a new
// request is taken in the cycle that the result is drained, but not before.
module multi_queue_shared_buffer_core #(
    parameter int SLOTS  = mqsb_pkg::SLOTS_DEF,
    parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] queue_id, [33:2] data_in, [39:34] zero
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] data_out
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // Pointer width includes the null value, which equals SLOTS.
    localparam int AW  = $clog2(SLOTS);
    localparam int PW  = $clog2(SLOTS + 1);
    // Only queues that a two-bit queue number can reach are given pointers.
    localparam int QN  = (QUEUES < (1 << mqsb_pkg::QID_W)) ? QUEUES : (1 << mqsb_pkg::QID_W);
    localparam int QIW = (QN > 1) ? $clog2(QN) : 1;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    mqsb_pkg::state_t state_reg, state_next;

    logic [PW-1:0]  head_reg [QN];
    logic [PW-1:0]  tail_reg [QN];
    logic [PW-1:0]  head_next [QN];
    logic [PW-1:0]  tail_next [QN];
    logic [PW-1:0]  free_head_reg, free_head_next;
    logic [PW-1:0]  hw_reg, hw_next;

    // Request held between the accept cycle and the write-back cycle.
    logic           kind_reg, kind_next;
    logic [QIW-1:0] qi_reg, qi_next;
    logic           op_ok_reg, op_ok_next;
    logic [PW-1:0]  idx_reg, idx_next;
    logic           virgin_reg, virgin_next;

    logic                        out_valid_reg, out_valid_next;
    logic [mqsb_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    mqsb_pkg::status_t           out_stat_reg, out_stat_next;

    logic                        req_kind;
    logic [mqsb_pkg::QID_W-1:0]  req_qid;
    logic [mqsb_pkg::DATA_W-1:0] req_data;
    logic [QIW-1:0]              req_qi;
    logic                        req_q_ok;
    logic [PW-1:0]               req_head;
    logic [PW-1:0]               req_tail;
    logic                        accept;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [PW-1:0]               link_rd;
    logic [mqsb_pkg::DATA_W-1:0] data_rd;
    logic                        link_we;
    logic [AW-1:0]               link_wa;
    logic [PW-1:0]               link_wd;
    logic                        data_we;
    logic [AW-1:0]               data_wa;
    logic [PW-1:0]               link_val;

    assign req_kind = s_axis_tuser[0];
    assign req_qid  = s_axis_tdata[1:0];
    assign req_data = s_axis_tdata[33:2];
    assign req_q_ok = int'(req_qid) < QN;
    assign req_qi   = req_q_ok ? QIW'(req_qid) : '0;
    assign req_head = head_reg[req_qi];
    assign req_tail = tail_reg[req_qi];

    assign s_axis_tready = (state_reg == mqsb_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Link of the slot being worked on: slots at or above the high-water mark were never
    // written and are taken as chained to the next slot.
    always_comb
    begin
        if (virgin_reg)
        begin
            link_val = PW'(idx_reg + 1'b1);
        end
        else if (link_rd < NIL)
        begin
            link_val = link_rd;
        end
        else
        begin
            link_val = NIL;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        hw_next        = hw_reg;
        kind_next      = kind_reg;
        qi_next        = qi_reg;
        op_ok_next     = op_ok_reg;
        idx_next       = idx_reg;
        virgin_next    = virgin_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_stat_next  = out_stat_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        link_we        = 1'b0;
        link_wa        = '0;
        link_wd        = NIL;
        data_we        = 1'b0;
        data_wa        = free_head_reg[AW-1:0];

        unique case (state_reg)
            mqsb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mqsb_pkg::ST_EXEC;
                    kind_next  = req_kind;
                    qi_next    = req_qi;
                    if (req_kind == mqsb_pkg::KIND_ENQ)
                    begin
                        op_ok_next = req_q_ok && (free_head_reg < NIL);
                        idx_next   = free_head_reg;
                        rd_en      = op_ok_next;
                        rd_addr    = free_head_reg[AW-1:0];
                        data_we    = op_ok_next;
                        // A non-empty queue gets the new slot linked behind its tail.
                        if (op_ok_next && (req_head < NIL) && (req_tail < NIL))
                        begin
                            link_we = 1'b1;
                            link_wa = req_tail[AW-1:0];
                            link_wd = free_head_reg;
                        end
                    end
                    else
                    begin
                        op_ok_next = req_q_ok && (req_head < NIL);
                        idx_next   = req_head;
                        rd_en      = op_ok_next;
                        rd_addr    = req_head[AW-1:0];
                    end
                    virgin_next = idx_next >= hw_reg;
                end
            end
            mqsb_pkg::ST_EXEC:
            begin
                state_next     = mqsb_pkg::ST_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = '0;
                if (!op_ok_reg)
                begin
                    out_stat_next = (kind_reg == mqsb_pkg::KIND_ENQ) ? mqsb_pkg::STAT_OVER
                                                                      : mqsb_pkg::STAT_UNDER;
                end
                else if (kind_reg == mqsb_pkg::KIND_ENQ)
                begin
                    out_stat_next  = mqsb_pkg::STAT_OK;
                    free_head_next = link_val;
                    if (!(head_reg[qi_reg] < NIL))
                    begin
                        head_next[qi_reg] = idx_reg;
                    end
                    tail_next[qi_reg] = idx_reg;
                    link_we = 1'b1;
                    link_wa = idx_reg[AW-1:0];
                    link_wd = NIL;
                    if (idx_reg == hw_reg)
                    begin
                        hw_next = PW'(hw_reg + 1'b1);
                    end
                end
                else
                begin
                    out_stat_next     = mqsb_pkg::STAT_OK;
                    out_data_next     = data_rd;
                    head_next[qi_reg] = link_val;
                    free_head_next    = idx_reg;
                    link_we = 1'b1;
                    link_wa = idx_reg[AW-1:0];
                    link_wd = free_head_reg;
                end
            end
            default:
            begin
                state_next = mqsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mqsb_pkg::ST_IDLE;
            free_head_reg <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < QN; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        qi_reg       <= qi_next;
        op_ok_reg    <= op_ok_next;
        idx_reg      <= idx_next;
        virgin_reg   <= virgin_next;
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
    end

    mqsb_store #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .PW    (PW)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .link_rd (link_rd),
        .data_rd (data_rd),
        .link_we (link_we),
        .link_wa (link_wa),
        .link_wd (link_wd),
        .data_we (data_we),
        .data_wa (data_wa),
        .data_wd (req_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_stat_reg;

    // An accepted request is always followed by its write-back cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == mqsb_pkg::ST_EXEC)
        else $error("accepted request not followed by write-back");

    // The write-back cycle always leaves a result in the output register.
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mqsb_pkg::ST_EXEC |=> m_axis_tvalid)
        else $error("write-back gave no result");

    // No request is taken while a result is pending and not being drained.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken over an undrained result");

    // The high-water mark and the free-list head never leave the slot range.
    a_hw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hw_reg <= NIL) && (free_head_reg <= NIL))
        else $error("pointer beyond slot range");

    // The high-water mark only moves on a successful enqueue.
    a_hw_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (hw_reg != $past(hw_reg)) |-> $past(state_reg == mqsb_pkg::ST_EXEC && op_ok_reg
                                            && kind_reg == mqsb_pkg::KIND_ENQ))
        else $error("high-water mark moved without an enqueue");

endmodule

// ===== hw/rtl/mqsb_store.sv =====
`timescale 1ns / 1ps
// Slot store of the multi-queue shared buffer: the data memory and the link memory,
// each with one write port and one registered read port. Uses mqsb_pkg.
module mqsb_store #(
    parameter int SLOTS = mqsb_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(SLOTS),
    parameter int PW    = $clog2(SLOTS + 1)
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [PW-1:0]               link_rd,
    output logic [mqsb_pkg::DATA_W-1:0] data_rd,
    input  logic                        link_we,
    input  logic [AW-1:0]               link_wa,
    input  logic [PW-1:0]               link_wd,
    input  logic                        data_we,
    input  logic [AW-1:0]               data_wa,
    input  logic [mqsb_pkg::DATA_W-1:0] data_wd
);

    logic [PW-1:0]               link_mem [SLOTS];
    logic [mqsb_pkg::DATA_W-1:0] data_mem [SLOTS];
    logic [PW-1:0]               link_rd_reg;
    logic [mqsb_pkg::DATA_W-1:0] data_rd_reg;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (rd_en)
        begin
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end
        if (rd_en)
        begin
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    assign link_rd = link_rd_reg;
    assign data_rd = data_rd_reg;

endmodule

// ===== test/multi_queue_shared_buffer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_queue_shared_buffer_core: a directed table and then
// random enqueue/dequeue traffic, checked against a behavioural model of the queues.
// Depends on mqsb_pkg and the core RTL; reads no files.
module multi_queue_shared_buffer_core_test;

    localparam int SLOTS        = mqsb_pkg::SLOTS_DEF;
    localparam int QUEUES       = mqsb_pkg::QUEUES_DEF;
    localparam int PTR_W        = $clog2(SLOTS + 1);
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 120;       // final stretch with no idling on either side
    localparam int SEGMENT      = 60;        // traffic mix is re-chosen every SEGMENT requests
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int DIRECTED_N   = 25;
    localparam int EXPECT_DEPTH = 16;        // far more than the core can have outstanding

    localparam logic ENQ = mqsb_pkg::KIND_ENQ;
    localparam logic DEQ = mqsb_pkg::KIND_DEQ;
    localparam mqsb_pkg::status_t S_OK    = mqsb_pkg::STAT_OK;
    localparam mqsb_pkg::status_t S_OVER  = mqsb_pkg::STAT_OVER;
    localparam mqsb_pkg::status_t S_UNDER = mqsb_pkg::STAT_UNDER;

    typedef logic [PTR_W-1:0] ptr_t;
    localparam ptr_t NIL = ptr_t'(SLOTS);

    typedef struct packed {
        logic [31:0]       word;
        mqsb_pkg::status_t status;
    } queue_result_t;

    // One row of the directed table. Where 'typed' is set the expected result is written
    // out in the row; otherwise it comes from the queue model.
    typedef struct packed {
        logic              kind;
        logic [1:0]        queue;
        logic [31:0]       word;
        logic              typed;
        logic [31:0]       want_word;
        mqsb_pkg::status_t want_status;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_N] = '{
        // Dequeue straight after reset: every queue is empty.
        '{DEQ, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, S_UNDER},
        // Extremes of the data word go in and come back out in order.
        '{ENQ, 2'd0, 32'h7fff_ffff, 1'b1, 32'h0000_0000, S_OK},
        '{ENQ, 2'd0, 32'h8000_0000, 1'b1, 32'h0000_0000, S_OK},
        '{DEQ, 2'd0, 32'hffff_ffff, 1'b1, 32'h7fff_ffff, S_OK},
        '{DEQ, 2'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, S_OK},
        // Queue 0 is now empty with a stale tail; the next enqueue must make a new head.
        '{DEQ, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, S_UNDER},
        '{ENQ, 2'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, S_OK},
        '{DEQ, 2'd3, 32'h0000_0000, 1'b1, 32'h0000_0000, S_UNDER},
        // Fill every remaining slot, spread across all queues.
        '{ENQ, 2'd1, 32'hffff_ffff, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd2, 32'h5555_5555, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd3, 32'haaaa_aaaa, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd0, 32'h0000_0001, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd1, 32'h8000_0000, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd2, 32'h7fff_ffff, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd3, 32'h1234_5678, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd3, 32'hdead_beef, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd1, 32'hfedc_ba98, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd2, 32'h0f0f_0f0f, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd2, 32'hf0f0_f0f0, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd1, 32'h00ff_00ff, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd0, 32'hff00_ff00, 1'b0, 32'h0000_0000, S_OK},
        '{ENQ, 2'd3, 32'h3c3c_3c3c, 1'b0, 32'h0000_0000, S_OK},
        // No slot is free any more.
        '{ENQ, 2'd2, 32'hffff_ffff, 1'b1, 32'h0000_0000, S_OVER},
        '{DEQ, 2'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, S_OK}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // [1:0] queue_id, [33:2] data_in, [39:34] zero
    logic [0:0]  s_axis_tuser;     // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] data_out
    logic [1:0]  m_axis_tuser;     // [1:0] status

    // Model of the shared store: words, next links, queue ends and the free list.
    logic [31:0] model_word [SLOTS];
    ptr_t        model_next [SLOTS];
    ptr_t        model_head [QUEUES];
    ptr_t        model_tail [QUEUES];
    ptr_t        model_free;
    int          slots_in_use;

    // Expected results in request order, kept in a small ring.
    queue_result_t expect_ring [EXPECT_DEPTH];
    int            expect_wr;
    int            expect_rd;
    int            expect_count;

    bit idling_on;
    int cycle_count;
    int mismatch_count;
    int results_seen;
    int enqueue_ok_count;
    int dequeue_ok_count;
    int overflow_count;
    int underflow_count;
    int peak_in_use;

    multi_queue_shared_buffer_core #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns period.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic bit is_slot(ptr_t p);
        return int'(p) < SLOTS;
    endfunction

    function automatic void reset_queue_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            model_word[i] = '0;
            model_next[i] = ptr_t'(i + 1);
        end
        model_next[SLOTS-1] = NIL;
        for (int q = 0; q < QUEUES; q++)
        begin
            model_head[q] = NIL;
            model_tail[q] = NIL;
        end
        model_free   = '0;
        slots_in_use = 0;
    endfunction

    function automatic void expect_store(queue_result_t r);
        expect_ring[expect_wr] = r;
        expect_wr              = (expect_wr + 1) % EXPECT_DEPTH;
        expect_count++;
    endfunction

    function automatic queue_result_t expect_take();
        queue_result_t r;
        r         = expect_ring[expect_rd];
        expect_rd = (expect_rd + 1) % EXPECT_DEPTH;
        expect_count--;
        return r;
    endfunction

    // Applies one request to the model and returns the result the core should give.
    // Any link that does not name a real slot is taken as the end of its chain.
    function automatic queue_result_t buffer_apply(logic req_kind, logic [1:0] req_queue,
                                                   logic [31:0] req_word);
        queue_result_t res;
        ptr_t          slot;
        ptr_t          tail;
        res.word   = '0;
        res.status = S_OK;
        if (req_kind == ENQ)
        begin
            if (int'(req_queue) >= QUEUES || !is_slot(model_free))
            begin
                res.status = S_OVER;
                overflow_count++;
            end
            else
            begin
                slot       = model_free;
                model_free = is_slot(model_next[slot[SLOT_W-1:0]])
                             ? model_next[slot[SLOT_W-1:0]] : NIL;
                tail       = model_tail[req_queue];
                if (!is_slot(model_head[req_queue]))
                    model_head[req_queue] = slot;
                else if (is_slot(tail))
                    model_next[tail[SLOT_W-1:0]] = slot;
                model_next[slot[SLOT_W-1:0]] = NIL;
                model_tail[req_queue]        = slot;
                model_word[slot[SLOT_W-1:0]] = req_word;
                slots_in_use++;
                enqueue_ok_count++;
                if (slots_in_use > peak_in_use)
                    peak_in_use = slots_in_use;
            end
        end
        else
        begin
            if (int'(req_queue) >= QUEUES || !is_slot(model_head[req_queue]))
            begin
                res.status = S_UNDER;
                underflow_count++;
            end
            else
            begin
                // The tail is left alone when the queue empties; it is stale from then on.
                slot                  = model_head[req_queue];
                model_head[req_queue] = is_slot(model_next[slot[SLOT_W-1:0]])
                                        ? model_next[slot[SLOT_W-1:0]] : NIL;
                model_next[slot[SLOT_W-1:0]] = model_free;
                model_free            = slot;
                res.word              = model_word[slot[SLOT_W-1:0]];
                slots_in_use--;
                dequeue_ok_count++;
            end
        end
        return res;
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatch_count < REPORT_MAX)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        mismatch_count++;
    endfunction

    // Offers one request, holding it until the core takes it. Entered and left at a
    // falling edge; tvalid stays high on exit so back-to-back requests need no gap.
    task automatic issue_request(input logic req_kind, input logic [1:0] req_queue,
                                 input logic [31:0] req_word, input logic use_typed,
                                 input queue_result_t typed_result);
        queue_result_t predicted;
        int            gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, req_word, req_queue};
        s_axis_tuser  <= req_kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = buffer_apply(req_kind, req_queue, req_word);
        expect_store(use_typed ? typed_result : predicted);
        @(negedge clk);
    endtask

    // Called at a falling edge with tvalid already lowered; returns at a falling edge.
    task automatic wait_results_drained();
        while (expect_count != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: random stall bursts while idling is on, always ready otherwise.
    initial
    begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                stall_left    = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Every result taken is compared with the oldest expectation, field by field.
    always @(posedge clk)
    begin : result_check
        queue_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expect_count == 0)
                report_mismatch("result with nothing outstanding", 32'h0, m_axis_tdata);
            else
            begin
                want = expect_take();
                if (m_axis_tdata !== want.word)
                    report_mismatch("data_out", want.word, m_axis_tdata);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expect_count);
            $display("multi_queue_shared_buffer_core_test: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        queue_result_t typed;
        int            enq_bias;
        int            focus_queue;
        logic          req_kind;
        logic [1:0]    req_queue;
        logic [31:0]   req_word;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idling_on     = 1'b1;
        expect_wr     = 0;
        expect_rd     = 0;
        expect_count  = 0;
        reset_queue_model();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        for (int r = 0; r < DIRECTED_N; r++)
        begin
            typed.word   = DIRECTED[r].want_word;
            typed.status = DIRECTED[r].want_status;
            issue_request(DIRECTED[r].kind, DIRECTED[r].queue, DIRECTED[r].word,
                          DIRECTED[r].typed, typed);
        end

        // Let the core empty its output before the random traffic begins.
        s_axis_tvalid <= 1'b0;
        wait_results_drained();

        // Random traffic. Each segment picks an enqueue bias, so the store swings
        // between full (overflow) and empty (underflow, stale tails), and sometimes
        // aims at one queue so that long chains build up.
        enq_bias    = 50;
        focus_queue = -1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % SEGMENT == 0)
            begin
                enq_bias    = $urandom_range(1, 9) * 10;
                focus_queue = ($urandom_range(0, 2) == 0) ? $urandom_range(0, QUEUES - 1) : -1;
                idling_on   = $urandom_range(0, 3) != 0;
            end
            if (i >= RANDOM_ITEMS - QUIET_ITEMS)
                idling_on = 1'b0;

            req_kind  = ($urandom_range(0, 99) < enq_bias) ? ENQ : DEQ;
            req_queue = (focus_queue >= 0) ? focus_queue[1:0] : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       req_word = 32'h8000_0000;
                1:       req_word = 32'h7fff_ffff;
                2:       req_word = 32'hffff_ffff;
                3:       req_word = 32'h0000_0000;
                default: req_word = $urandom;
            endcase
            issue_request(req_kind, req_queue, req_word, 1'b0, typed);

            // Halfway through, hold off until every outstanding result has come back.
            if (i == RANDOM_ITEMS / 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait_results_drained();
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d results checked: %0d enqueues, %0d dequeues, %0d overflows, %0d underflows",
                 results_seen, enqueue_ok_count, dequeue_ok_count, overflow_count,
                 underflow_count);
        $display("peak store occupancy %0d of %0d slots, %0d mismatches",
                 peak_in_use, SLOTS, mismatch_count);
        if (mismatch_count == 0 && expect_count == 0)
            $display("multi_queue_shared_buffer_core_test: done, clean");
        else
            $display("multi_queue_shared_buffer_core_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mqsb_pkg.sv
hw/rtl/mqsb_store.sv
hw/rtl/multi_queue_shared_buffer_core.sv
test/multi_queue_shared_buffer_core_test.sv
